>>> src/mbs_pkg.sv
// Package for the maze backtracker step unit: defaults, state and direction codes, helpers.
`timescale 1ns / 1ps

package mbs_pkg;

    // Default grid size
    localparam int COLS_DEF = 32;
    localparam int ROWS_DEF = 32;

    // Width of the reported coordinates
    localparam int COORD_W = 5;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep of the visited memory after reset
        ST_IDLE,    // waiting for a step request
        ST_SCAN,    // reading the four neighbour bits of the stack top
        ST_EVAL,    // carve or pop
        ST_POP,     // new stack top comes back from the stack memory
        ST_DONE     // result waits for the output register
    } t_state;

    // Neighbour order: north, south, west, east
    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_S = 2'd1,
        DIR_W = 2'd2,
        DIR_E = 2'd3
    } t_dir;

    // 16-bit value modulo 3: base-4 digits all weigh 1 mod 3
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

>>> src/mbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mbs_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/maze_backtracker_step_unit.sv
// Top level of the maze backtracker step unit: depth-first carving over RAM-held state.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------------
//   step     | in        | i_valid / o_ready  | i_random_value
//   carve    | out       | o_valid / i_ready  | o_from_col o_from_row o_to_col o_to_row
//            |           |                    | o_finished
//
// A step scans the four neighbours of the stack top through the single read port of the visited
// RAM, and scans again for every dead-end cell popped. After reset a sweep over all
// 2**(clog2(COLS)+clog2(ROWS)) addresses (1024 at 32x32) clears the visited RAM; no step request
// is taken meanwhile. A new request is taken while a previous result still waits on a stalled
// output.
`timescale 1ns / 1ps

module maze_backtracker_step_unit #(
    parameter int COLS = mbs_pkg::COLS_DEF,
    parameter int ROWS = mbs_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // step requests
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [15:0]                 i_random_value,
    // carve results
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mbs_pkg::COORD_W-1:0] o_from_col,
    output logic [mbs_pkg::COORD_W-1:0] o_from_row,
    output logic [mbs_pkg::COORD_W-1:0] o_to_col,
    output logic [mbs_pkg::COORD_W-1:0] o_to_row,
    output logic                        o_finished
);

    localparam int CW     = $clog2(COLS);
    localparam int RW     = $clog2(ROWS);
    localparam int AW     = CW + RW;            // visited address {row, col}
    localparam int NCELLS = COLS * ROWS;
    localparam int SAW    = $clog2(NCELLS);     // stack index
    localparam int DW     = $clog2(NCELLS + 1); // stack depth
    localparam int CW_MAX = COLS - 1;
    localparam int RW_MAX = ROWS - 1;
    localparam int START  = COLS / 2;

    localparam logic [CW-1:0] START_COL = CW'(START);
    localparam logic [CW-1:0] LAST_COL  = CW'(CW_MAX);
    localparam logic [RW-1:0] LAST_ROW  = RW'(RW_MAX);
    localparam logic [AW-1:0] START_ADR = {RW'(0), START_COL};

    mbs_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_clr_addr;
    logic [CW-1:0] r_top_col;
    logic [RW-1:0] r_top_row;
    logic [DW-1:0] r_depth;
    logic [1:0]    r_rnd_lo;
    logic [1:0]    r_rnd_m3;
    logic [2:0]    r_scan_cnt;
    logic          r_rd_ok;
    logic [3:0]    r_free;

    // pending result
    logic [CW-1:0] r_res_from_col, r_res_to_col;
    logic [RW-1:0] r_res_from_row, r_res_to_row;
    logic          r_res_fin;

    // output register
    logic                        r_out_valid;
    logic [mbs_pkg::COORD_W-1:0] r_o_from_col, r_o_from_row, r_o_to_col, r_o_to_row;
    logic                        r_o_fin;

    // memory ports
    logic          vis_we, vis_wdata, vis_rdata;
    logic [AW-1:0] vis_waddr, vis_raddr;
    logic          stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [AW-1:0] stk_wdata, stk_rdata;

    // neighbour being read in the scan
    mbs_pkg::t_dir scan_dir;
    logic [CW-1:0] nb_col;
    logic [RW-1:0] nb_row;
    logic          nb_ok;
    logic [1:0]    prev_dir;

    // carve decision
    logic [2:0]    open_cnt;
    logic [1:0]    pick;
    mbs_pkg::t_dir pick_dir;
    logic [CW-1:0] to_col;
    logic [RW-1:0] to_row;
    logic          can_push;
    logic [DW-1:0] pop_depth;
    logic          step_acc;

    assign step_acc = i_valid && o_ready;
    assign prev_dir = 2'(r_scan_cnt - 3'd1);

    // neighbour address and range check for the current scan slot
    always_comb begin
        scan_dir = mbs_pkg::t_dir'(r_scan_cnt[1:0]);
        nb_col   = r_top_col;
        nb_row   = r_top_row;
        nb_ok    = 1'b0;
        unique case (scan_dir)
            mbs_pkg::DIR_N: begin
                nb_row = r_top_row - RW'(1);
                nb_ok  = (r_top_row != '0);
            end
            mbs_pkg::DIR_S: begin
                nb_row = r_top_row + RW'(1);
                nb_ok  = (r_top_row != LAST_ROW);
            end
            mbs_pkg::DIR_W: begin
                nb_col = r_top_col - CW'(1);
                nb_ok  = (r_top_col != '0);
            end
            mbs_pkg::DIR_E: begin
                nb_col = r_top_col + CW'(1);
                nb_ok  = (r_top_col != LAST_COL);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // count of open neighbours and the one the random word picks
    always_comb begin
        logic [1:0] seen;
        open_cnt = 3'(r_free[0]) + 3'(r_free[1]) + 3'(r_free[2]) + 3'(r_free[3]);
        case (open_cnt)
            3'd2:    pick = {1'b0, r_rnd_lo[0]};
            3'd3:    pick = r_rnd_m3;
            3'd4:    pick = r_rnd_lo;
            default: pick = 2'd0;
        endcase
        seen     = 2'd0;
        pick_dir = mbs_pkg::DIR_N;
        for (int d = 0; d < 4; d++) begin
            if (r_free[d]) begin
                if (seen == pick) begin
                    pick_dir = mbs_pkg::t_dir'(2'(d));
                end
                seen = seen + 2'd1;
            end
        end
        to_col = r_top_col;
        to_row = r_top_row;
        unique case (pick_dir)
            mbs_pkg::DIR_N: to_row = r_top_row - RW'(1);
            mbs_pkg::DIR_S: to_row = r_top_row + RW'(1);
            mbs_pkg::DIR_W: to_col = r_top_col - CW'(1);
            mbs_pkg::DIR_E: to_col = r_top_col + CW'(1);
            default:        to_col = r_top_col;
        endcase
    end

    assign can_push  = (r_depth < DW'(NCELLS));
    assign pop_depth = r_depth - DW'(1);

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        vis_we    = 1'b0;
        vis_waddr = r_clr_addr;
        vis_wdata = 1'b0;
        vis_raddr = {nb_row, nb_col};
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = START_ADR;
        stk_raddr = SAW'(pop_depth - DW'(1));
        unique case (r_state)
            mbs_pkg::ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_wdata = (r_clr_addr == START_ADR);
                stk_we    = 1'b1;
                if (&r_clr_addr) begin
                    n_state = mbs_pkg::ST_IDLE;
                end
            end
            mbs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (r_depth == '0) ? mbs_pkg::ST_DONE : mbs_pkg::ST_SCAN;
                end
            end
            mbs_pkg::ST_SCAN: begin
                if (r_scan_cnt == 3'd4) begin
                    n_state = mbs_pkg::ST_EVAL;
                end
            end
            mbs_pkg::ST_EVAL: begin
                if (open_cnt != 3'd0) begin
                    vis_we    = 1'b1;
                    vis_waddr = {to_row, to_col};
                    vis_wdata = 1'b1;
                    stk_we    = can_push;
                    stk_waddr = SAW'(r_depth);
                    stk_wdata = {to_row, to_col};
                    n_state   = mbs_pkg::ST_DONE;
                end else if (pop_depth == '0) begin
                    n_state = mbs_pkg::ST_DONE;
                end else begin
                    n_state = mbs_pkg::ST_POP;
                end
            end
            mbs_pkg::ST_POP: begin
                n_state = mbs_pkg::ST_SCAN;
            end
            mbs_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = mbs_pkg::ST_IDLE;
                end
            end
            default: n_state = mbs_pkg::ST_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbs_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_depth     <= DW'(1);
            r_top_col   <= START_COL;
            r_top_row   <= '0;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mbs_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (step_acc) begin
                r_scan_cnt <= '0;
            end
            if (r_state == mbs_pkg::ST_SCAN) begin
                r_scan_cnt <= r_scan_cnt + 3'd1;
            end
            if (r_state == mbs_pkg::ST_EVAL) begin
                if (open_cnt != 3'd0) begin
                    if (can_push) begin
                        r_depth   <= r_depth + DW'(1);
                        r_top_col <= to_col;
                        r_top_row <= to_row;
                    end
                end else begin
                    r_depth <= pop_depth;
                end
            end
            if (r_state == mbs_pkg::ST_POP) begin
                r_top_col  <= stk_rdata[CW-1:0];
                r_top_row  <= stk_rdata[AW-1:CW];
                r_scan_cnt <= '0;
            end
            // output register handshake: a new result wins over the one just taken
            if (r_state == mbs_pkg::ST_DONE && n_state == mbs_pkg::ST_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_rnd_lo <= i_random_value[1:0];
            r_rnd_m3 <= mbs_pkg::mod3_16(i_random_value);
            if (r_depth == '0) begin
                r_res_fin      <= 1'b1;
                r_res_from_col <= '0;
                r_res_from_row <= '0;
                r_res_to_col   <= '0;
                r_res_to_row   <= '0;
            end
        end
        // neighbour bit returns in the cycle after its read
        if (r_state == mbs_pkg::ST_SCAN) begin
            r_rd_ok <= nb_ok;
            if (r_scan_cnt != 3'd0) begin
                r_free[prev_dir] <= r_rd_ok && !vis_rdata;
            end
        end
        if (r_state == mbs_pkg::ST_EVAL) begin
            if (open_cnt != 3'd0) begin
                r_res_fin      <= 1'b0;
                r_res_from_col <= r_top_col;
                r_res_from_row <= r_top_row;
                r_res_to_col   <= to_col;
                r_res_to_row   <= to_row;
            end else if (pop_depth == '0) begin
                r_res_fin      <= 1'b1;
                r_res_from_col <= '0;
                r_res_from_row <= '0;
                r_res_to_col   <= '0;
                r_res_to_row   <= '0;
            end
        end
        if (r_state == mbs_pkg::ST_DONE && n_state == mbs_pkg::ST_IDLE) begin
            r_o_from_col <= mbs_pkg::COORD_W'(r_res_from_col);
            r_o_from_row <= mbs_pkg::COORD_W'(r_res_from_row);
            r_o_to_col   <= mbs_pkg::COORD_W'(r_res_to_col);
            r_o_to_row   <= mbs_pkg::COORD_W'(r_res_to_row);
            r_o_fin      <= r_res_fin;
        end
    end

    // visited bitmap, one bit per cell at {row, col}
    mbs_ram #(
        .P_WIDTH(1),
        .P_DEPTH(2 ** AW)
    ) u_visited (
        .i_clk  (i_clk),
        .i_we   (vis_we),
        .i_waddr(vis_waddr),
        .i_wdata(vis_wdata),
        .i_raddr(vis_raddr),
        .o_rdata(vis_rdata)
    );

    // cell stack; the top entry is also held in r_top_col / r_top_row
    mbs_ram #(
        .P_WIDTH(AW),
        .P_DEPTH(NCELLS)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    assign o_ready    = (r_state == mbs_pkg::ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_from_col = r_o_from_col;
    assign o_from_row = r_o_from_row;
    assign o_to_col   = r_o_to_col;
    assign o_to_row   = r_o_to_row;
    assign o_finished = r_o_fin;

endmodule

>>> src/mbs_checker.sv
// Port-level checker for the maze backtracker step unit, bound to the top level.
`timescale 1ns / 1ps

module mbs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [15:0]                 i_random_value,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [mbs_pkg::COORD_W-1:0] o_from_col,
    input logic [mbs_pkg::COORD_W-1:0] o_from_row,
    input logic [mbs_pkg::COORD_W-1:0] o_to_col,
    input logic [mbs_pkg::COORD_W-1:0] o_to_row,
    input logic                        o_finished
);

    logic r_seen_fin;

    // a finished result has been delivered since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fin <= 1'b0;
        end else if (o_valid && i_ready && o_finished) begin
            r_seen_fin <= 1'b1;
        end
    end

    // waiting request holds
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_random_value))
        else $error("request dropped or changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_from_col) && $stable(o_from_row)
            && $stable(o_to_col) && $stable(o_to_row) && $stable(o_finished))
        else $error("result changed while stalled");

    // once finished, always finished
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen_fin |-> o_finished)
        else $error("carve result after finished");

    // finished carries zero coordinates
    a_fin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> o_from_col == '0 && o_from_row == '0
            && o_to_col == '0 && o_to_row == '0)
        else $error("finished result with coordinates");

    // a carved passage joins two adjacent cells
    a_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_finished |->
            (o_to_col == o_from_col
                && (o_to_row == mbs_pkg::COORD_W'(o_from_row + 1'b1)
                    || o_from_row == mbs_pkg::COORD_W'(o_to_row + 1'b1)))
            || (o_to_row == o_from_row
                && (o_to_col == mbs_pkg::COORD_W'(o_from_col + 1'b1)
                    || o_from_col == mbs_pkg::COORD_W'(o_to_col + 1'b1))))
        else $error("passage between cells that are not neighbours");

endmodule

bind maze_backtracker_step_unit mbs_checker u_mbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_random_value(i_random_value),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_from_col    (o_from_col),
    .o_from_row    (o_from_row),
    .o_to_col      (o_to_col),
    .o_to_row      (o_to_row),
    .o_finished    (o_finished)
);

>>> verif/maze_backtracker_step_unit_tb.sv
// Testbench for the maze backtracker step unit: directed steps, then carving until the maze is full.
`timescale 1ns / 1ps

module maze_backtracker_step_unit_tb;

    localparam int COLS         = mbs_pkg::COLS_DEF;
    localparam int ROWS         = mbs_pkg::ROWS_DEF;
    localparam int CELLS        = COLS * ROWS;
    localparam int W            = mbs_pkg::COORD_W;
    localparam int RANDOM_STEPS = 1000;
    localparam int DONE_REPEATS = 8;       // steps to take once the maze is complete
    localparam int WATCHDOG     = 60000;   // clearing sweep plus a full unwind of the stack
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [W-1:0] from_col;
        logic [W-1:0] from_row;
        logic [W-1:0] to_col;
        logic [W-1:0] to_row;
        logic         finished;
    } carve_t;

    typedef struct {
        logic [15:0] rnd;
        bit          typed;    // expected carve written in by hand
        carve_t      want;
    } step_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_ready;
    logic [15:0]  i_random_value;
    logic         o_valid;
    logic         i_ready;
    logic [W-1:0] o_from_col;
    logic [W-1:0] o_from_row;
    logic [W-1:0] o_to_col;
    logic [W-1:0] o_to_row;
    logic         o_finished;

    maze_backtracker_step_unit #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_random_value (i_random_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_from_col     (o_from_col),
        .o_from_row     (o_from_row),
        .o_to_col       (o_to_col),
        .o_to_row       (o_to_row),
        .o_finished     (o_finished)
    );

    // Directed steps from reset; the first three are worked out by hand from the start cell
    step_row_t dir_steps [20] = '{
        '{16'h0000, 1'b1, '{5'd16, 5'd0, 5'd16, 5'd1, 1'b0}},   // start, pick south
        '{16'hFFFF, 1'b1, '{5'd16, 5'd1, 5'd16, 5'd2, 1'b0}},   // 65535 mod 3 = 0, south
        '{16'hFFFE, 1'b1, '{5'd16, 5'd2, 5'd17, 5'd2, 1'b0}},   // 65534 mod 3 = 2, east
        '{16'h0001, 1'b0, '0},
        '{16'h0002, 1'b0, '0},
        '{16'h0003, 1'b0, '0},
        '{16'h8000, 1'b0, '0},
        '{16'h7FFF, 1'b0, '0},
        '{16'hAAAA, 1'b0, '0},
        '{16'h5555, 1'b0, '0},
        '{16'h0004, 1'b0, '0},
        '{16'hFFFD, 1'b0, '0},
        '{16'h00FF, 1'b0, '0},
        '{16'hFF00, 1'b0, '0},
        '{16'h0F0F, 1'b0, '0},
        '{16'hF0F0, 1'b0, '0},
        '{16'h0006, 1'b0, '0},
        '{16'h0005, 1'b0, '0},
        '{16'hFFFC, 1'b0, '0},
        '{16'h1234, 1'b0, '0}
    };

    // Predictor state: visited cells and the carving trail (cells as row*COLS+col)
    bit           visited [CELLS];
    logic [9:0]   trail [CELLS];
    int unsigned  trail_depth;

    carve_t       carve_due [$];
    int           mismatches;
    int           results_seen;
    int           finished_due;
    int           idle_cycles;
    bit           cur_typed;
    carve_t       cur_want;
    int           burst_left;

    // Pop dead ends, then carve into the open neighbour picked by rnd
    function automatic carve_t carve_next(input logic [15:0] rnd);
        int     col;
        int     row;
        int     cnt;
        int     top;
        int     pick;
        int     nc [4];
        int     nr [4];
        carve_t r;
        r = '0;
        cnt = 0;
        while (trail_depth > 0) begin
            top = trail[trail_depth - 1];
            col = top % COLS;
            row = top / COLS;
            cnt = 0;
            if (row > 0 && !visited[(row - 1) * COLS + col]) begin
                nc[cnt] = col; nr[cnt] = row - 1; cnt++;
            end
            if (row + 1 < ROWS && !visited[(row + 1) * COLS + col]) begin
                nc[cnt] = col; nr[cnt] = row + 1; cnt++;
            end
            if (col > 0 && !visited[row * COLS + col - 1]) begin
                nc[cnt] = col - 1; nr[cnt] = row; cnt++;
            end
            if (col + 1 < COLS && !visited[row * COLS + col + 1]) begin
                nc[cnt] = col + 1; nr[cnt] = row; cnt++;
            end
            if (cnt > 0) begin
                break;
            end
            trail_depth--;
        end
        if (trail_depth == 0) begin
            r.finished = 1'b1;
            return r;
        end
        pick = int'(rnd) % cnt;
        visited[nr[pick] * COLS + nc[pick]] = 1'b1;
        if (trail_depth < CELLS) begin
            trail[trail_depth] = 10'(nr[pick] * COLS + nc[pick]);
            trail_depth++;
        end
        r.from_col = W'(col);
        r.from_row = W'(row);
        r.to_col   = W'(nc[pick]);
        r.to_row   = W'(nr[pick]);
        return r;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Scoreboard: check results against the oldest expectation, predict each accepted request
    always @(posedge i_clk) begin
        carve_t want;
        carve_t got;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (carve_due.size() == 0) begin
                $display("%0t: carve result with nothing expected", $time);
                mismatches++;
            end else begin
                want = carve_due.pop_front();
                if (o_from_col !== want.from_col) begin
                    $display("%0t: from_col exp %0d got %0d", $time, want.from_col, o_from_col);
                    mismatches++;
                end
                if (o_from_row !== want.from_row) begin
                    $display("%0t: from_row exp %0d got %0d", $time, want.from_row, o_from_row);
                    mismatches++;
                end
                if (o_to_col !== want.to_col) begin
                    $display("%0t: to_col exp %0d got %0d", $time, want.to_col, o_to_col);
                    mismatches++;
                end
                if (o_to_row !== want.to_row) begin
                    $display("%0t: to_row exp %0d got %0d", $time, want.to_row, o_to_row);
                    mismatches++;
                end
                if (o_finished !== want.finished) begin
                    $display("%0t: finished exp %0b got %0b", $time, want.finished, o_finished);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            got = carve_next(i_random_value);
            if (got.finished) begin
                finished_due++;
            end
            carve_due.push_back(cur_typed ? cur_want : got);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("maze_backtracker_step_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: rotating stall pattern, reshuffled when its age counter runs out, plus two long hold-offs
    initial begin
        int          hold_left;
        int          next_hold_at;
        int          pat_age;
        logic [15:0] pattern;
        hold_left    = 0;
        next_hold_at = 200;
        pat_age      = 0;
        pattern      = '1;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (results_seen >= next_hold_at && next_hold_at <= 600) begin
                i_ready <= 1'b0;
                hold_left = 300;
                next_hold_at += 400;
            end else begin
                if (pat_age == 0) begin
                    pat_age = 64;
                    case ($urandom_range(0, 3))
                        0: pattern = '1;
                        1: pattern = 16'($urandom);
                        2: pattern = 16'($urandom) | 16'($urandom);
                        default: pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
                    endcase
                end
                i_ready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
                pat_age--;
            end
        end
    end

    // Offer one step request and hold it until taken; then maybe idle before the next
    task automatic offer_step(input logic [15:0] rnd, input bit typed, input carve_t want);
        int gap;
        cur_typed = typed;
        cur_want  = want;
        i_valid        <= 1'b1;
        i_random_value <= rnd;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        cur_typed = 1'b0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid        <= 1'b0;
                i_random_value <= 16'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Main sequence
    initial begin
        logic [15:0] rnd;
        int          sent;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_random_value = '0;
        i_ready        = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        finished_due   = 0;
        idle_cycles    = 0;
        cur_typed      = 1'b0;
        cur_want       = '0;
        burst_left     = 0;
        // predictor starts from the reset state: start cell in the middle of the top row
        foreach (visited[k]) visited[k] = 1'b0;
        foreach (trail[k]) trail[k] = '0;
        visited[COLS / 2] = 1'b1;
        trail[0]          = 10'(COLS / 2);
        trail_depth       = 1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_steps[k]) begin
            offer_step(dir_steps[k].rnd, dir_steps[k].typed, dir_steps[k].want);
        end

        // random carving until the grid is full and a few finished steps have followed
        sent = 0;
        while (sent < RANDOM_STEPS || finished_due < DONE_REPEATS) begin
            case ($urandom_range(0, 3))
                0: rnd = 16'($urandom_range(0, 15));
                1: rnd = 16'($urandom_range(65520, 65535));
                2: rnd = ($urandom_range(0, 1) == 1) ? 16'(1 << $urandom_range(0, 15))
                                                     : ~16'(1 << $urandom_range(0, 15));
                default: rnd = 16'($urandom_range(0, 65535));
            endcase
            offer_step(rnd, 1'b0, '0);
            sent++;
        end
        i_valid <= 1'b0;

        while (carve_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && carve_due.size() == 0) begin
            $display("maze_backtracker_step_unit test passed");
        end else begin
            $display("maze_backtracker_step_unit test failed");
        end
        $finish;
    end

endmodule
